/* rtl/core/adtpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the two-point ADC gain/offset calculator.
// No dependencies.
package adtpc_pkg;

	localparam int FIELD_W = 12;
	localparam int REG_W   = 8;
	localparam int GQ_W    = 12;
	localparam int OQ_W    = 13;

	localparam logic [FIELD_W-1:0] OUT_MAX  = 12'd4095;
	localparam int                 NEG_BIAS = 2049;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SPAN = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_LOW_NUM  = 2'd0,
		REG_LOW_DEN  = 2'd1,
		REG_HIGH_NUM = 2'd2,
		REG_HIGH_DEN = 2'd3
	} reg_idx_t;

endpackage

/* rtl/core/adc_two_point_gain_offset_calc_core.sv */
`timescale 1ns / 1ps
// Two-point ADC gain/offset calculator, top level.
// Uses adtpc_pkg, adtpc_ideal_div and adtpc_div_steps.
//
// Takes one pair of measured codes per cycle, unless out_ready or a divider run
// holds the flow, and returns gain (1.11) and offset corrections plus status;
// stalls are absorbed stage by stage. Ideal reference codes are formed by two
// bit-serial dividers that run after reset and after every configuration
// write; while they run, in_ready stays low.
// Gain and offset quotients come from a four-stage restoring divider.
module adc_two_point_gain_offset_calc_core import adtpc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [REG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FIELD_W-1:0] measured_low_code,
	input  logic [FIELD_W-1:0] measured_high_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] gain_correction,
	output logic [FIELD_W-1:0] offset_correction,
	output logic [1:0]         status
);

	localparam int IW = ADC_BITS + REG_W;
	localparam int PW = IW + FIELD_W;
	localparam int NSTG = 7;

	typedef struct packed {
		logic [GQ_W:0]        g_rem;
		logic [GQ_W:0]        g_div;
		logic [GQ_W-1:0]      g_lo;
		logic [GQ_W-1:0]      g_q;
		logic [IW-1:0]        o_rem;
		logic [IW-1:0]        o_div;
		logic [OQ_W-1:0]      o_lo;
		logic [OQ_W-1:0]      o_q;
		logic [FIELD_W-1:0]   m_low;
		logic                 err;
		logic                 gsat;
		logic                 osat;
	} dv_t;

	// configuration and ideal codes
	logic [REG_W-1:0] low_num_q, low_den_q, high_num_q, high_den_q;
	logic             start_q;
	logic             low_busy, high_busy, calib_busy;
	logic [IW-1:0]    i_low, i_high;
	logic             cfg_acc, in_acc;

	assign cfg_ready  = 1'b1;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign calib_busy = start_q || low_busy || high_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_num_q  <= 8'd1;
			low_den_q  <= 8'd11;
			high_num_q <= 8'd10;
			high_den_q <= 8'd11;
			start_q    <= 1'b1;
		end else begin
			start_q <= cfg_acc;
			if (cfg_acc) begin
				case (reg_idx_t'(cfg_index))
					REG_LOW_NUM:  low_num_q  <= cfg_data;
					REG_LOW_DEN:  low_den_q  <= cfg_data;
					REG_HIGH_NUM: high_num_q <= cfg_data;
					REG_HIGH_DEN: high_den_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	adtpc_ideal_div #(.SH(ADC_BITS), .QW(IW)) u_low_div (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.num(low_num_q), .den(low_den_q), .busy(low_busy), .quo(i_low)
	);

	adtpc_ideal_div #(.SH(ADC_BITS), .QW(IW)) u_high_div (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.num(high_num_q), .den(high_den_q), .busy(high_busy), .quo(i_high)
	);

	// handshake
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] adv;

	always_comb begin
		adv[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_ready = adv[1] && !calib_busy;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_s[k] <= (k == 1) ? in_acc : vld_s[k-1];
				end
			end
		end
	end

	// stage 1: spans, error check, offset product
	logic signed [FIELD_W:0] m_span;
	logic signed [IW:0]      i_span;
	logic                    err;
	logic [FIELD_W-1:0]      m_low_s1, m_span_s1;
	logic [IW-1:0]           i_span_s1;
	logic [PW-1:0]           prod_s1;
	logic                    err_s1;

	assign m_span = $signed({1'b0, measured_high_code}) - $signed({1'b0, measured_low_code});
	assign i_span = $signed({1'b0, i_high}) - $signed({1'b0, i_low});
	assign err    = (low_den_q == '0) || (high_den_q == '0) ||
	                (m_span <= 0) || (i_span <= 0);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_low_s1  <= measured_low_code;
			m_span_s1 <= m_span[FIELD_W-1:0];
			i_span_s1 <= i_span[IW-1:0];
			prod_s1   <= PW'(m_span[FIELD_W-1:0]) * PW'(i_low);
			err_s1    <= err;
		end
	end

	// stage 2: saturation checks and divider setup
	dv_t dv_s [0:4];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dv_s[0].g_rem <= i_span_s1[GQ_W:0];
			dv_s[0].g_div <= {m_span_s1, 1'b0};
			dv_s[0].g_lo  <= m_span_s1;
			dv_s[0].g_q   <= '0;
			dv_s[0].o_rem <= IW'(prod_s1[PW-1:OQ_W]);
			dv_s[0].o_div <= i_span_s1;
			dv_s[0].o_lo  <= prod_s1[OQ_W-1:0];
			dv_s[0].o_q   <= '0;
			dv_s[0].m_low <= m_low_s1;
			dv_s[0].err   <= err_s1;
			dv_s[0].gsat  <= i_span_s1 >= IW'({m_span_s1, 1'b0});
			dv_s[0].osat  <= {1'b0, prod_s1[PW-1:OQ_W]} >= i_span_s1;
		end
	end

	// stages 3..6: restoring division, gain 3 bits and offset 3 or 4 bits each
	for (genvar k = 0; k < 4; k++) begin : g_div
		localparam int GS = 3;
		localparam int GH = GQ_W - 1 - GS * k;
		localparam int OS = (k == 0) ? 4 : 3;
		localparam int OH = (k == 0) ? OQ_W - 1 : OQ_W - 5 - 3 * (k - 1);

		dv_t           nxt;
		logic [GQ_W:0] g_rem;
		logic [GS-1:0] g_q;
		logic [IW-1:0] o_rem;
		logic [OS-1:0] o_q;

		adtpc_div_steps #(.RW(GQ_W + 1), .NS(GS)) u_gain (
			.rem_i(dv_s[k].g_rem), .bits_i(dv_s[k].g_lo[GH -: GS]),
			.div_i(dv_s[k].g_div), .rem_o(g_rem), .q_o(g_q)
		);

		adtpc_div_steps #(.RW(IW), .NS(OS)) u_off (
			.rem_i(dv_s[k].o_rem), .bits_i(dv_s[k].o_lo[OH -: OS]),
			.div_i(dv_s[k].o_div), .rem_o(o_rem), .q_o(o_q)
		);

		always_comb begin
			nxt               = dv_s[k];
			nxt.g_rem         = g_rem;
			nxt.g_q[GH -: GS] = g_q;
			nxt.o_rem         = o_rem;
			nxt.o_q[OH -: OS] = o_q;
		end

		always_ff @(posedge clk) begin
			if (adv[k+3]) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// stage 7: truncation toward zero, clamping, encoding
	logic signed [OQ_W+1:0] t, t_adj;
	logic                   off_low;
	logic [FIELD_W-1:0]     gain_s7, off_s7;
	status_t                status_s7;

	assign t       = $signed({3'b0, dv_s[4].m_low}) - $signed({2'b0, dv_s[4].o_q});
	assign t_adj   = ((dv_s[4].o_rem != '0) && (t > 0)) ? t - 15'sd1 : t;
	assign off_low = dv_s[4].osat || (t_adj < -15'(NEG_BIAS));

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			if (dv_s[4].err) begin
				gain_s7   <= '0;
				off_s7    <= '0;
				status_s7 <= ST_SPAN;
			end else begin
				gain_s7 <= dv_s[4].gsat ? OUT_MAX : dv_s[4].g_q;
				if (off_low) begin
					off_s7 <= '0;
				end else if (t_adj < 0) begin
					off_s7 <= FIELD_W'(t_adj + 15'(NEG_BIAS));
				end else begin
					off_s7 <= FIELD_W'(t_adj);
				end
				status_s7 <= (dv_s[4].gsat || off_low) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid         = vld_s[NSTG];
	assign gain_correction   = gain_s7;
	assign offset_correction = off_s7;
	assign status            = status_s7;

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SPAN |-> gain_correction == '0 && offset_correction == '0)
		else $error("span error with nonzero result");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("item accepted before ideal codes refreshed");

	a_calib_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(low_busy || high_busy) |-> !(in_valid && in_ready))
		else $error("item accepted while ideal divider busy");

endmodule

/* rtl/core/adtpc_div_steps.sv */
`timescale 1ns / 1ps
// A few restoring-division steps, combinational, MSB first.
// Uses adtpc_pkg; instantiated by the calculator pipeline.
module adtpc_div_steps import adtpc_pkg::*; #(
	parameter int RW = 13,
	parameter int NS = 3
) (
	input  logic [RW-1:0] rem_i,
	input  logic [NS-1:0] bits_i,
	input  logic [RW-1:0] div_i,
	output logic [RW-1:0] rem_o,
	output logic [NS-1:0] q_o
);

	always_comb begin
		logic [RW-1:0] r;
		logic [RW:0]   trial;
		r   = rem_i;
		q_o = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			trial = {r, bits_i[i]};
			if (trial >= {1'b0, div_i}) begin
				r      = RW'(trial - {1'b0, div_i});
				q_o[i] = 1'b1;
			end else begin
				r = trial[RW-1:0];
			end
		end
		rem_o = r;
	end

endmodule

/* rtl/core/adtpc_ideal_div.sv */
`timescale 1ns / 1ps
// Bit-serial divider for ideal reference codes: floor(num * 2^SH / den).
// Uses adtpc_pkg; one quotient bit per cycle.
module adtpc_ideal_div import adtpc_pkg::*; #(
	parameter int SH = 12,
	parameter int QW = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REG_W-1:0] num,
	input  logic [REG_W-1:0] den,
	output logic             busy,
	output logic [QW-1:0]    quo
);

	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0]    cnt_q;
	logic [QW-1:0]    dvd_q;
	logic [QW-1:0]    quo_q;
	logic [REG_W-1:0] rem_q;
	logic [REG_W-1:0] den_q;
	logic [REG_W:0]   trial;

	assign trial = {rem_q, dvd_q[QW-1]};
	assign busy  = (cnt_q != '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= QW'({num, {SH{1'b0}}});
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= REG_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[REG_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

endmodule
